@@ hdl/mbr_pkg.sv @@
// Shared types and constants for the multi-channel byte ring.
package mbr_pkg;

   // Parameter defaults
   localparam int CHANNELS_DEF = 4;
   localparam int CAPACITY_DEF = 256;

   // Channel field width as seen on the request port
   localparam int CH_W = 2;

   // Operation codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Classified operation handed from the front end to the back end
   typedef struct packed {
      logic            is_read;
      logic            in_range;
      logic [CH_W-1:0] channel;
      logic [7:0]      write_data;
      logic            batch_end;
   } op_type;

endpackage

@@ hdl/multi_channel_byte_ring.sv @@
// Top level of the multi-channel byte ring.
// Holds up to four independent byte rings of CAPACITY bytes each (power of two);
// writes land at a working head that becomes visible to reads and to the fill
// level only on a beat with batch_end set, and every request beat yields one
// response beat. An item passes two back-end states: S_IDLE updates the
// channel pointers and addresses the byte memory, S_FILL moves the registered
// memory read into the response register. No new item is taken until the last
// has left S_FILL, and only while the response slot is free or draining. A
// two-entry queue sits between the request side and the back end. Full rings
// are not detected: overfilling wraps and the fill level reads modulo CAPACITY.
module multi_channel_byte_ring #(
   parameter int CHANNELS = mbr_pkg::CHANNELS_DEF,
   parameter int CAPACITY = mbr_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [mbr_pkg::CH_W-1:0] req_channel,
   input  logic [7:0]               req_write_data,
   input  logic                     req_batch_end,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_read_valid,
   output logic [7:0]               rsp_fill_level
);

   logic            push_valid, push_ready, pop_valid, pop_ready;
   mbr_pkg::op_type push_op, pop_op;

   // Classify incoming beats
   mbr_front #(.CHANNELS(CHANNELS)) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_channel    (req_channel),
      .req_write_data (req_write_data),
      .req_batch_end  (req_batch_end),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_op        (push_op)
   );

   // Decoupling queue
   mbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Ring execution
   mbr_back #(.CHANNELS(CHANNELS), .CAPACITY(CAPACITY)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_op         (pop_op),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_read_valid (rsp_read_valid),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

@@ hdl/mbr_front.sv @@
// Front end: accepts request beats and classifies them for the back end.
module mbr_front #(
   parameter int CHANNELS = mbr_pkg::CHANNELS_DEF
) (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [mbr_pkg::CH_W-1:0] req_channel,
   input  logic [7:0]              req_write_data,
   input  logic                    req_batch_end,
   output logic                    push_valid,
   input  logic                    push_ready,
   output mbr_pkg::op_type         push_op
);

   localparam int CH_SPAN = 1 << mbr_pkg::CH_W;

   // Channel range check; channels past the configured count are flagged out of range
   logic in_range;
   always_comb begin
      if (CHANNELS >= CH_SPAN) begin
         in_range = 1'b1;
      end else begin
         in_range = ({1'b0, req_channel} < (mbr_pkg::CH_W + 1)'(CHANNELS));
      end
   end

   // Build the operation record
   always_comb begin
      push_op.is_read    = (req_func == mbr_pkg::FUNC_READ);
      push_op.in_range   = in_range;
      push_op.channel    = req_channel;
      push_op.write_data = req_write_data;
      push_op.batch_end  = req_batch_end & (req_func == mbr_pkg::FUNC_WRITE);
   end

   assign push_valid = req_valid;
   assign req_stall  = ~push_ready;

endmodule

@@ hdl/mbr_queue.sv @@
// Two-entry queue decoupling the front end from the back end.
module mbr_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  mbr_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output mbr_pkg::op_type pop_op
);

   mbr_pkg::op_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_fire, pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push_fire  = push_valid & push_ready;
   assign pop_fire   = pop_valid & pop_ready;
   assign pop_op     = slot_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_fire) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop_fire)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push_fire, pop_fire})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ hdl/mbr_back.sv @@
// Back end: ring pointers, byte memory and the response register.
module mbr_back #(
   parameter int CHANNELS = mbr_pkg::CHANNELS_DEF,
   parameter int CAPACITY = mbr_pkg::CAPACITY_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  mbr_pkg::op_type pop_op,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_read_valid,
   output logic [7:0]      rsp_fill_level
);

   // Only four channels are addressable through the request port
   localparam int CH_SPAN = 1 << mbr_pkg::CH_W;
   localparam int USED    = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
   localparam int IDX_W   = (USED > 1) ? $clog2(USED) : 1;
   localparam int PTR_W   = $clog2(CAPACITY);
   localparam int DEPTH   = USED * CAPACITY;
   localparam int ADDR_W  = $clog2(DEPTH);

   typedef enum logic {S_IDLE, S_FILL} state_type;

   state_type  state_ff;
   logic       pend_ok_ff;
   logic [7:0] pend_fill_ff;
   logic       rsp_valid_ff, rsp_read_valid_ff;
   logic [7:0] rsp_read_data_ff, rsp_fill_level_ff;

   logic [PTR_W-1:0] pub_ff  [USED];
   logic [PTR_W-1:0] wh_ff   [USED];
   logic [PTR_W-1:0] tail_ff [USED];
   logic [PTR_W-1:0] pub_in  [USED];
   logic [PTR_W-1:0] wh_in   [USED];
   logic [PTR_W-1:0] tail_in [USED];

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              wr_en;

   logic             pop_fire;
   logic [IDX_W-1:0] idx;
   logic [PTR_W-1:0] cur_pub, cur_wh, cur_tail, wh_next;
   logic [PTR_W-1:0] new_pub, new_tail;
   logic [PTR_W-1:0] fill_diff;
   logic             ok_in;
   logic [7:0]       fill_in;

   // Take a new op when idle and the response slot is free or draining
   assign pop_ready = (state_ff == S_IDLE) & (~rsp_valid_ff | ~rsp_stall);
   assign pop_fire  = pop_valid & pop_ready;

   assign idx      = IDX_W'(pop_op.channel);
   assign cur_pub  = pub_ff[idx];
   assign cur_wh   = wh_ff[idx];
   assign cur_tail = tail_ff[idx];
   assign wh_next  = cur_wh + PTR_W'(1);

   // Execute one op against the selected channel
   always_comb begin
      pub_in   = pub_ff;
      wh_in    = wh_ff;
      tail_in  = tail_ff;
      new_pub  = cur_pub;
      new_tail = cur_tail;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      if (pop_fire && pop_op.in_range) begin
         if (!pop_op.is_read) begin
            wr_en      = 1'b1;
            wh_in[idx] = wh_next;
            if (pop_op.batch_end) begin
               new_pub     = wh_next;
               pub_in[idx] = wh_next;
            end
         end else if (cur_tail != cur_pub) begin
            ok_in        = 1'b1;
            new_tail     = cur_tail + PTR_W'(1);
            tail_in[idx] = new_tail;
         end
      end
      // Fill wraps at the ring size before it is cut to the port width
      fill_diff = new_pub - new_tail;
      if (pop_op.in_range) begin
         fill_in = 8'(fill_diff);
      end else begin
         fill_in = 8'd0;
      end
   end

   assign wr_addr = ADDR_W'({idx, cur_wh});
   assign rd_addr = ADDR_W'({idx, cur_tail});

   // Byte memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= pop_op.write_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Per-channel pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < USED; i++) begin
            pub_ff[i]  <= '0;
            wh_ff[i]   <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         pub_ff  <= pub_in;
         wh_ff   <= wh_in;
         tail_ff <= tail_in;
      end
   end

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_fire) begin
                  pend_ok_ff   <= ok_in;
                  pend_fill_ff <= fill_in;
                  state_ff     <= S_FILL;
               end
            end
            S_FILL: begin
               rsp_valid_ff      <= 1'b1;
               rsp_read_valid_ff <= pend_ok_ff;
               rsp_read_data_ff  <= pend_ok_ff ? rd_data_ff : 8'd0;
               rsp_fill_level_ff <= pend_fill_ff;
               state_ff          <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_read_valid = rsp_read_valid_ff;
   assign rsp_fill_level = rsp_fill_level_ff;

endmodule

@@ hdl/mbr_checker.sv @@
// Port-level checker for the multi-channel byte ring, bound to the top level.
module mbr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     req_func,
   input logic [mbr_pkg::CH_W-1:0] req_channel,
   input logic [7:0]               req_write_data,
   input logic                     req_batch_end,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [7:0]               rsp_read_data,
   input logic                     rsp_read_valid,
   input logic [7:0]               rsp_fill_level
);

   // Beats accepted but not yet answered
   logic [3:0] outstanding_ff;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid & ~req_stall;
   assign rsp_fire = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 4'd0;
      end else begin
         case ({req_fire, rsp_fire})
            2'b10:   outstanding_ff <= outstanding_ff + 4'd1;
            2'b01:   outstanding_ff <= outstanding_ff - 4'd1;
            default: outstanding_ff <= outstanding_ff;
         endcase
      end
   end

   // No response without a request still open
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 4'd0)
      else $error("response beat with no open request");

   // A stalled request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_func)
         && $stable(req_channel) && $stable(req_write_data) && $stable(req_batch_end))
      else $error("stalled request changed");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_read_valid) && $stable(rsp_fill_level))
      else $error("stalled response changed");

   // A response without a byte carries zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_data == 8'd0)
      else $error("nonzero data on a response without a byte");

   // Reset empties the response side
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind multi_channel_byte_ring mbr_checker u_mbr_checker (.*);
